// ===== rtl/lru_write_back_block_cache_tags_assert.svh =====
`ifndef LRU_WRITE_BACK_BLOCK_CACHE_TAGS_ASSERT_SVH
`define LRU_WRITE_BACK_BLOCK_CACHE_TAGS_ASSERT_SVH

// Checks that a condition in one cycle implies another in the same cycle.
`define LRUC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define LRUC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lruc_pkg.sv =====
package lruc_pkg;

    localparam int ENTRIES        = 64;
    localparam int SLOT_W         = $clog2(ENTRIES);
    localparam int CNT_W          = $clog2(ENTRIES + 1);
    localparam int BLOCK_NUM_BITS = 32;
    localparam int COUNT_W        = 32;
    localparam int FIELD_W        = 32;
    localparam int OUT_USED_W     = SLOT_W + 3 * FIELD_W;
    localparam int OUT_PAD_W      = 8 * ((OUT_USED_W + 7) / 8) - OUT_USED_W;

    localparam logic [1:0] OP_ACCESS = 2'd0;
    localparam logic [1:0] OP_FLUSH  = 2'd1;
    localparam logic [1:0] OP_RESET  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SCMP,
        S_VREAD,
        S_AEMIT,
        S_FLUSH,
        S_FEMIT
    } state_t;

    typedef struct packed {
        logic              rotate;
        logic              promote;
        logic [SLOT_W-1:0] promote_slot;
        logic [SLOT_W-1:0] promote_pos;
    } list_ctrl_t;

    typedef struct packed {
        logic [OUT_PAD_W-1:0] pad;
        logic [FIELD_W-1:0]   hit_total;
        logic [FIELD_W-1:0]   access_total;
        logic [FIELD_W-1:0]   writeback_block;
        logic [SLOT_W-1:0]    slot;
    } out_tdata_t;

endpackage

// ===== rtl/lruc_tag_ram.sv =====
module lruc_tag_ram
    import lruc_pkg::*;
(
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [SLOT_W-1:0]         wr_addr,
    input  logic [BLOCK_NUM_BITS-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [SLOT_W-1:0]         rd_addr,
    output logic [BLOCK_NUM_BITS-1:0] rd_data
);

    logic [BLOCK_NUM_BITS-1:0] mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // The read data holds between reads, so a result can wait on it.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/lruc_recency_list.sv =====
module lruc_recency_list
    import lruc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  list_ctrl_t        ctrl,
    output logic [SLOT_W-1:0] head,
    output logic [SLOT_W-1:0] tail
);

    // Position k holds the slot of rank k: the head is most recent, the tail least.
    logic [SLOT_W-1:0] order_reg [ENTRIES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ENTRIES; k++)
            begin
                order_reg[k] <= SLOT_W'(k);
            end
        end
        else if (ctrl.rotate)
        begin
            // A full turn of ENTRIES rotations leaves the order as it was.
            for (int k = 0; k < ENTRIES - 1; k++)
            begin
                order_reg[k] <= order_reg[k + 1];
            end
            order_reg[ENTRIES-1] <= order_reg[0];
        end
        else if (ctrl.promote)
        begin
            order_reg[0] <= ctrl.promote_slot;
            for (int k = 1; k < ENTRIES; k++)
            begin
                if (SLOT_W'(k) <= ctrl.promote_pos)
                begin
                    order_reg[k] <= order_reg[k - 1];
                end
            end
        end
    end

    assign head = order_reg[0];
    assign tail = order_reg[ENTRIES-1];

endmodule

// ===== rtl/lru_write_back_block_cache_tags.sv =====
// Tag and replacement controller of a fully associative write-back block cache
// with true LRU replacement.
// Input beats on s_*: op 0 looks a block up, op 1 writes back every dirty entry,
// op 2 does the same and then invalidates all entries and zeroes both counters.
// An access gives one result beat; a flush gives one beat per dirty entry,
// visited from most to least recent, with m_tlast on the final one, and no beat
// at all when nothing is dirty. Op 3 is dropped.
// An access walks the recency list in the tag search one entry a cycle through
// the single tag RAM read port, then passes a compare state, a victim read and
// the update state.
// A flush does the same walk and stops at each dirty entry to emit its beat.
// s_tready is high only while no item is in progress; the output register lets
// the next item be accepted while the previous result still waits.
// When m_tready is low the sequencer holds before its next result until the
// output register is free; no result is lost.
// After rst_n all entries are invalid and clean, slot i has rank i and both
// counters are zero; the tag RAM needs no clearing.
module lru_write_back_block_cache_tags
    import lruc_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,   // block_num
    input  logic [2:0]                  s_tuser,   // op[1:0], is_write
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // slot, writeback_block, access_total, hit_total, zero padding
    output logic [$bits(out_tdata_t)-1:0] m_tdata,
    output logic [2:0]                  m_tuser,   // hit, fetch, writeback
    output logic                        m_tlast
);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [1:0]                op_reg, op_next;
    logic [BLOCK_NUM_BITS-1:0] blk_reg, blk_next;
    logic                      wr_reg, wr_next;
    logic [ENTRIES-1:0]        valid_reg, valid_next;
    logic [ENTRIES-1:0]        dirty_reg, dirty_next;
    logic                      cmp_pend_reg, cmp_pend_next;
    logic                      cmp_ok_reg, cmp_ok_next;
    logic [SLOT_W-1:0]         cmp_slot_reg, cmp_slot_next;
    logic [SLOT_W-1:0]         cmp_pos_reg, cmp_pos_next;
    logic                      hit_reg, hit_next;
    logic [SLOT_W-1:0]         hit_slot_reg, hit_slot_next;
    logic [SLOT_W-1:0]         hit_pos_reg, hit_pos_next;
    logic [SLOT_W-1:0]         fl_slot_reg, fl_slot_next;
    logic [COUNT_W-1:0]        acc_cnt_reg, acc_cnt_next;
    logic [COUNT_W-1:0]        hit_cnt_reg, hit_cnt_next;
    logic                      out_valid_reg, out_valid_next;
    out_tdata_t                out_data_reg, out_data_next;
    logic [2:0]                out_user_reg, out_user_next;
    logic                      out_last_reg, out_last_next;

    logic                      ram_wr_en;
    logic [SLOT_W-1:0]         ram_wr_addr;
    logic                      ram_rd_en;
    logic [SLOT_W-1:0]         ram_rd_addr;
    logic [BLOCK_NUM_BITS-1:0] ram_rd_data;

    list_ctrl_t                list_ctrl;
    logic [SLOT_W-1:0]         head;
    logic [SLOT_W-1:0]         tail;

    logic                      out_free;
    logic [SLOT_W-1:0]         acc_slot;
    logic                      acc_wb;
    logic [ENTRIES-1:0]        clear_mask;
    logic                      finish;

    lruc_tag_ram u_tag_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (blk_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    lruc_recency_list u_recency (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (list_ctrl),
        .head  (head),
        .tail  (tail)
    );

    assign out_free   = !out_valid_reg || m_tready;
    assign acc_slot   = hit_reg ? hit_slot_reg : tail;
    assign acc_wb     = !hit_reg && valid_reg[tail] && dirty_reg[tail];
    assign clear_mask = ENTRIES'(1) << fl_slot_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            cmp_pend_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            acc_cnt_reg   <= '0;
            hit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            valid_reg     <= valid_next;
            dirty_reg     <= dirty_next;
            cmp_pend_reg  <= cmp_pend_next;
            hit_reg       <= hit_next;
            acc_cnt_reg   <= acc_cnt_next;
            hit_cnt_reg   <= hit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        blk_reg      <= blk_next;
        wr_reg       <= wr_next;
        cmp_ok_reg   <= cmp_ok_next;
        cmp_slot_reg <= cmp_slot_next;
        cmp_pos_reg  <= cmp_pos_next;
        hit_slot_reg <= hit_slot_next;
        hit_pos_reg  <= hit_pos_next;
        fl_slot_reg  <= fl_slot_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        op_next        = op_reg;
        blk_next       = blk_reg;
        wr_next        = wr_reg;
        valid_next     = valid_reg;
        dirty_next     = dirty_reg;
        cmp_pend_next  = 1'b0;
        cmp_ok_next    = cmp_ok_reg;
        cmp_slot_next  = cmp_slot_reg;
        cmp_pos_next   = cmp_pos_reg;
        hit_next       = hit_reg;
        hit_slot_next  = hit_slot_reg;
        hit_pos_next   = hit_pos_reg;
        fl_slot_next   = fl_slot_reg;
        acc_cnt_next   = acc_cnt_reg;
        hit_cnt_next   = hit_cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_last_next  = out_last_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = tail;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = head;
        list_ctrl      = '0;
        finish         = 1'b0;

        // The tag read issued in the previous search cycle is compared here.
        if (cmp_pend_reg && cmp_ok_reg && (ram_rd_data == blk_reg))
        begin
            hit_next      = 1'b1;
            hit_slot_next = cmp_slot_reg;
            hit_pos_next  = cmp_pos_reg;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next  = s_tuser[1:0];
                    blk_next = s_tdata[BLOCK_NUM_BITS-1:0];
                    wr_next  = s_tuser[2];
                    cnt_next = '0;
                    hit_next = 1'b0;
                    case (s_tuser[1:0]) inside
                        OP_ACCESS:
                        begin
                            acc_cnt_next = acc_cnt_reg + COUNT_W'(1);
                            state_next   = S_SEARCH;
                        end
                        OP_FLUSH, OP_RESET:
                        begin
                            state_next = S_FLUSH;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_SEARCH:
            begin
                ram_rd_en        = 1'b1;
                ram_rd_addr      = head;
                cmp_pend_next    = 1'b1;
                cmp_ok_next      = valid_reg[head];
                cmp_slot_next    = head;
                cmp_pos_next     = cnt_reg[SLOT_W-1:0];
                list_ctrl.rotate = 1'b1;
                cnt_next         = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(ENTRIES - 1))
                begin
                    state_next = S_SCMP;
                end
            end

            S_SCMP:
            begin
                state_next = S_VREAD;
            end

            S_VREAD:
            begin
                // Old tag of the victim, needed if it is written back.
                ram_rd_en   = 1'b1;
                ram_rd_addr = tail;
                state_next  = S_AEMIT;
            end

            S_AEMIT:
            begin
                if (out_free)
                begin
                    hit_cnt_next = hit_cnt_reg + COUNT_W'(hit_reg);
                    if (!hit_reg)
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = tail;
                    end
                    valid_next[acc_slot] = 1'b1;
                    dirty_next[acc_slot] = wr_reg || (hit_reg && dirty_reg[acc_slot]);

                    list_ctrl.promote      = 1'b1;
                    list_ctrl.promote_slot = acc_slot;
                    list_ctrl.promote_pos  = hit_reg ? hit_pos_reg : SLOT_W'(ENTRIES - 1);

                    out_valid_next                = 1'b1;
                    out_data_next.pad             = '0;
                    out_data_next.slot            = acc_slot;
                    out_data_next.writeback_block =
                        acc_wb ? FIELD_W'(ram_rd_data) : '0;
                    out_data_next.access_total    = FIELD_W'(acc_cnt_reg);
                    out_data_next.hit_total       =
                        FIELD_W'(hit_cnt_reg + COUNT_W'(hit_reg));
                    out_user_next                 = {acc_wb, !hit_reg, hit_reg};
                    out_last_next                 = 1'b1;
                    state_next                    = S_IDLE;
                end
            end

            S_FLUSH:
            begin
                list_ctrl.rotate = 1'b1;
                cnt_next         = cnt_reg + CNT_W'(1);
                if (valid_reg[head] && dirty_reg[head])
                begin
                    ram_rd_en    = 1'b1;
                    ram_rd_addr  = head;
                    fl_slot_next = head;
                    state_next   = S_FEMIT;
                end
                else if (cnt_reg == CNT_W'(ENTRIES - 1))
                begin
                    finish = 1'b1;
                end
            end

            S_FEMIT:
            begin
                if (out_free)
                begin
                    dirty_next[fl_slot_reg] = 1'b0;

                    out_valid_next                = 1'b1;
                    out_data_next.pad             = '0;
                    out_data_next.slot            = fl_slot_reg;
                    out_data_next.writeback_block = FIELD_W'(ram_rd_data);
                    out_data_next.access_total    = FIELD_W'(acc_cnt_reg);
                    out_data_next.hit_total       = FIELD_W'(hit_cnt_reg);
                    out_user_next                 = 3'b100;
                    // Final beat once no other valid dirty entry remains.
                    out_last_next = ((valid_reg & dirty_reg & ~clear_mask) == '0);

                    if (cnt_reg == CNT_W'(ENTRIES))
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        state_next = S_FLUSH;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish)
        begin
            state_next = S_IDLE;
            if (op_reg == OP_RESET)
            begin
                valid_next   = '0;
                dirty_next   = '0;
                acc_cnt_next = '0;
                hit_cnt_next = '0;
            end
        end
    end

endmodule

// ===== rtl/lruc_checker.sv =====
`include "lru_write_back_block_cache_tags_assert.svh"

module lruc_checker
    import lruc_pkg::*;
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [2:0]                    s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [$bits(out_tdata_t)-1:0] m_tdata,
    input logic [2:0]                    m_tuser
);

    `LRUC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")

    `LRUC_ASSERT_NOW(a_hit_clean, m_tvalid && m_tuser[0], !m_tuser[1] && !m_tuser[2], "hit with fetch or writeback")

    `LRUC_ASSERT_NOW(a_wb_block_zero, m_tvalid && !m_tuser[2], m_tdata[SLOT_W+FIELD_W-1:SLOT_W] == '0, "writeback block set without writeback")

    `LRUC_ASSERT_NOW(a_flush_wb, m_tvalid && !m_tuser[0] && !m_tuser[1], m_tuser[2], "flush beat without writeback")

    `LRUC_ASSERT_NEXT(a_busy_after_op, s_tvalid && s_tready && (s_tuser[1:0] != OP_UNUSED), !s_tready, "accepted a new item while one is in progress")

endmodule

bind lru_write_back_block_cache_tags lruc_checker u_lruc_checker (.*);
